>>> rtl/core/ocpg_pkg.sv
// Shared constants, types and the CORDIC arctangent table for the orbit
// camera path generator. No dependencies.
package ocpg_pkg;

  // CORDIC sine/cosine unit
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_DEPTH   = 30;
  localparam int ATAN_IDX_W   = $clog2(ATAN_DEPTH);
  localparam int CORDIC_CNT_W = $clog2(CORDIC_STEPS + 1);

  // gain-compensated 1.0 in Q2.30, and 1.0 in Q30
  localparam logic signed [31:0] CORDIC_ONE_K = 32'sh26DD3B6A;
  localparam logic signed [32:0] Q30_ONE      = 33'sh040000000;

  // shared multiplier: A times B, B taken in two halves
  localparam int MUL_A_W    = 33;
  localparam int MUL_B_W    = 32;
  localparam int MUL_HALF_W = 16;
  localparam int MUL_ACC_W  = MUL_A_W + MUL_B_W;

  // configuration register indexes
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MIN  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MAX  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_MIN  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_MAX  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ORBIT_RATE  = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_RATE = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_RATE = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 4'd7;

  typedef struct packed {
    logic                       start;
    logic signed [MUL_A_W-1:0]  a;
    logic signed [MUL_B_W-1:0]  b;
  } ocpg_mul_req_t;

  typedef struct packed {
    logic               done;
    logic [31:0]        prod_lo;  // low word of the exact product
    logic signed [31:0] rnd;      // (product + 2^29) >> 30, low word
  } ocpg_mul_rsp_t;

  // arctangent of 2^-i in turn units (2^32 per turn)
  function automatic logic [31:0] ocpg_atan(input logic [ATAN_IDX_W-1:0] idx);
    logic [31:0] val;
    case (idx)
      5'd0:    val = 32'h20000000;
      5'd1:    val = 32'h12E4051E;
      5'd2:    val = 32'h09FB385B;
      5'd3:    val = 32'h051111D4;
      5'd4:    val = 32'h028B0D43;
      5'd5:    val = 32'h0145D7E1;
      5'd6:    val = 32'h00A2F61E;
      5'd7:    val = 32'h00517C55;
      5'd8:    val = 32'h0028BE53;
      5'd9:    val = 32'h00145F2F;
      5'd10:   val = 32'h000A2F98;
      5'd11:   val = 32'h000517CC;
      5'd12:   val = 32'h00028BE6;
      5'd13:   val = 32'h000145F3;
      5'd14:   val = 32'h0000A2FA;
      5'd15:   val = 32'h0000517D;
      5'd16:   val = 32'h000028BE;
      5'd17:   val = 32'h0000145F;
      5'd18:   val = 32'h00000A30;
      5'd19:   val = 32'h00000518;
      5'd20:   val = 32'h0000028C;
      5'd21:   val = 32'h00000146;
      5'd22:   val = 32'h000000A3;
      5'd23:   val = 32'h00000051;
      5'd24:   val = 32'h00000029;
      5'd25:   val = 32'h00000014;
      5'd26:   val = 32'h0000000A;
      5'd27:   val = 32'h00000005;
      5'd28:   val = 32'h00000003;
      5'd29:   val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

>>> rtl/core/ocpg_cordic.sv
// Iterative rotation-mode CORDIC: sine and cosine in Q30 of a 32-bit phase.
// One micro-rotation per cycle, then a quadrant fold. Depends on ocpg_pkg.
module ocpg_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [31:0]        phase_i,
  output logic               done_o,
  output logic signed [31:0] sin_o,
  output logic signed [31:0] cos_o
);
  import ocpg_pkg::*;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_ITER = 2'd1;
  localparam logic [1:0] C_MAP  = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [CORDIC_CNT_W-1:0] cnt_q, cnt_d;
  logic signed [31:0]      x_q, x_d, y_q, y_d, z_q, z_d;
  logic [1:0]              quad_q, quad_d;
  logic signed [31:0]      sin_q, sin_d, cos_q, cos_d;
  logic                    done_q, done_d;

  logic signed [31:0] dx, dy, at;

  assign dx = y_q >>> cnt_q;
  assign dy = x_q >>> cnt_q;
  assign at = $signed(ocpg_atan(ATAN_IDX_W'(cnt_q)));

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    quad_d  = quad_q;
    sin_d   = sin_q;
    cos_d   = cos_q;
    done_d  = 1'b0;
    unique case (state_q)
      C_IDLE: ;
      C_ITER: begin
        // rotate toward zero residual angle
        if (!z_q[31]) begin
          x_d = x_q - dx;
          y_d = y_q + dy;
          z_d = z_q - at;
        end else begin
          x_d = x_q + dx;
          y_d = y_q - dy;
          z_d = z_q + at;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CORDIC_CNT_W'(CORDIC_STEPS - 1)) begin
          state_d = C_MAP;
        end
      end
      C_MAP: begin
        case (quad_q)
          2'd0: begin cos_d = x_q;  sin_d = y_q;  end
          2'd1: begin cos_d = -y_q; sin_d = x_q;  end
          2'd2: begin cos_d = -x_q; sin_d = -y_q; end
          2'd3: begin cos_d = y_q;  sin_d = -x_q; end
        endcase
        done_d  = 1'b1;
        state_d = C_IDLE;
      end
      default: state_d = C_IDLE;
    endcase
    if (start_i) begin
      state_d = C_ITER;
      cnt_d   = '0;
      x_d     = CORDIC_ONE_K;
      y_d     = '0;
      z_d     = $signed({2'b00, phase_i[29:0]});
      quad_d  = phase_i[31:30];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    quad_q <= quad_d;
    sin_q  <= sin_d;
    cos_q  <= cos_d;
  end

  assign done_o = done_q;
  assign sin_o  = sin_q;
  assign cos_o  = cos_q;

endmodule

>>> rtl/core/ocpg_mul.sv
// Shared multiplier: signed 33 x 32 product built from two 16-bit halves
// of B, low then high, then a rounding shift by 30. Depends on ocpg_pkg.
module ocpg_mul (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ocpg_pkg::ocpg_mul_req_t req_i,
  output ocpg_pkg::ocpg_mul_rsp_t rsp_o
);
  import ocpg_pkg::*;

  localparam logic [1:0] M_IDLE = 2'd0;
  localparam logic [1:0] M_LO   = 2'd1;
  localparam logic [1:0] M_HI   = 2'd2;
  localparam logic [1:0] M_RND  = 2'd3;

  localparam int ROUND_SHIFT = 30;
  localparam logic signed [MUL_ACC_W-1:0] ROUND_BIAS =
    MUL_ACC_W'(64'sd1 <<< (ROUND_SHIFT - 1));

  localparam int P_LO_W = MUL_A_W + MUL_HALF_W + 1;
  localparam int P_HI_W = MUL_A_W + MUL_B_W - MUL_HALF_W;

  logic [1:0]                  state_q, state_d;
  logic signed [MUL_A_W-1:0]   a_q, a_d;
  logic signed [MUL_B_W-1:0]   b_q, b_d;
  logic signed [MUL_ACC_W-1:0] acc_q, acc_d;
  logic signed [31:0]          rnd_q, rnd_d;
  logic                        done_q, done_d;

  logic signed [P_LO_W-1:0]    p_lo;
  logic signed [P_HI_W-1:0]    p_hi;
  logic signed [MUL_ACC_W-1:0] acc_rnd, acc_shr;

  assign p_lo    = a_q * $signed({1'b0, b_q[MUL_HALF_W-1:0]});
  assign p_hi    = a_q * $signed(b_q[MUL_B_W-1:MUL_HALF_W]);
  assign acc_rnd = acc_q + ROUND_BIAS;
  assign acc_shr = acc_rnd >>> ROUND_SHIFT;

  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    acc_d   = acc_q;
    rnd_d   = rnd_q;
    done_d  = 1'b0;
    unique case (state_q)
      M_IDLE: ;
      M_LO: begin
        acc_d   = MUL_ACC_W'(p_lo);
        state_d = M_HI;
      end
      M_HI: begin
        acc_d   = acc_q + $signed({p_hi, {MUL_HALF_W{1'b0}}});
        state_d = M_RND;
      end
      M_RND: begin
        rnd_d   = acc_shr[31:0];
        done_d  = 1'b1;
        state_d = M_IDLE;
      end
      default: state_d = M_IDLE;
    endcase
    if (req_i.start) begin
      a_d     = req_i.a;
      b_d     = req_i.b;
      state_d = M_LO;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
    rnd_q <= rnd_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.prod_lo = acc_q[31:0];
  assign rsp_o.rnd     = rnd_q;

endmodule

>>> rtl/core/orbit_camera_path_generator.sv
// Orbit camera path generator: one eye point per frame transaction, circling
// the target point. Depends on ocpg_pkg, ocpg_cordic and ocpg_mul.
//
// Each frame holds in_ready_o low from its acceptance until its last phase
// advance is done. The frame time is set by one iterative CORDIC run three
// times (radius sweep, height sweep, orbit angle) at one micro-rotation per
// cycle, and by one shared multiplier for the two sweeps, the two eye
// offsets and the three phase advances. A finished eye point waits in an
// output register; the phase advances run only once that register is free.
// Configuration writes take effect at once and are meant for idle periods;
// a write of start_angle also reloads the orbit phase.
module orbit_camera_path_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ocpg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [15:0]                    delta_ms_i,
  input  logic signed [31:0]             target_x_i,
  input  logic signed [31:0]             target_y_i,
  input  logic signed [31:0]             target_z_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [31:0]             eye_x_o,
  output logic signed [31:0]             eye_y_o,
  output logic signed [31:0]             eye_z_o
);
  import ocpg_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_R_COR  = 4'd1;
  localparam logic [3:0] S_R_MUL  = 4'd2;
  localparam logic [3:0] S_H_COR  = 4'd3;
  localparam logic [3:0] S_H_MUL  = 4'd4;
  localparam logic [3:0] S_O_COR  = 4'd5;
  localparam logic [3:0] S_X_MUL  = 4'd6;
  localparam logic [3:0] S_Y_MUL  = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;
  localparam logic [3:0] S_PO_MUL = 4'd9;
  localparam logic [3:0] S_PR_MUL = 4'd10;
  localparam logic [3:0] S_PH_MUL = 4'd11;

  logic [3:0] state_q, state_d;

  // configuration
  logic [30:0]        radius_min_q, radius_min_d, radius_max_q, radius_max_d;
  logic signed [31:0] height_min_q, height_min_d, height_max_q, height_max_d;
  logic [31:0]        orbit_rate_q, orbit_rate_d, radius_rate_q, radius_rate_d;
  logic [31:0]        height_rate_q, height_rate_d, start_angle_q, start_angle_d;

  // phase accumulators
  logic [31:0] orbit_phase_q, orbit_phase_d;
  logic [31:0] radius_phase_q, radius_phase_d;
  logic [31:0] height_phase_q, height_phase_d;

  // captured transaction and intermediate results
  logic [15:0]        delta_q, delta_d;
  logic signed [31:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d, tgt_z_q, tgt_z_d;
  logic signed [31:0] radius_q, radius_d, height_q, height_d;
  logic signed [31:0] off_x_q, off_x_d, off_y_q, off_y_d;

  // output register
  logic               out_valid_q, out_valid_d;
  logic signed [31:0] eye_x_q, eye_x_d, eye_y_q, eye_y_d, eye_z_q, eye_z_d;

  // shared units
  logic               cor_start;
  logic [31:0]        cor_phase;
  logic               cor_done;
  logic signed [31:0] cor_sin, cor_cos;
  ocpg_mul_req_t      mul_req;
  ocpg_mul_rsp_t      mul_rsp;

  // sweep factor and operands
  logic signed [32:0] t_sum, t_half;
  logic signed [31:0] t_q30;
  logic signed [32:0] r_diff, h_diff;

  ocpg_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .phase_i (cor_phase),
    .done_o  (cor_done),
    .sin_o   (cor_sin),
    .cos_o   (cor_cos)
  );

  ocpg_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // t = (sin + 1.0) / 2 in Q30, clamped to [0, 1.0]
  always_comb begin
    t_sum  = {cor_sin[31], cor_sin} + Q30_ONE;
    t_half = t_sum >>> 1;
    if (t_half[32]) begin
      t_q30 = '0;
    end else if (t_half > Q30_ONE) begin
      t_q30 = Q30_ONE[31:0];
    end else begin
      t_q30 = t_half[31:0];
    end
  end

  assign r_diff = $signed({2'b00, radius_max_q}) - $signed({2'b00, radius_min_q});
  assign h_diff = {height_max_q[31], height_max_q} - {height_min_q[31], height_min_q};

  always_comb begin
    state_d        = state_q;
    radius_min_d   = radius_min_q;
    radius_max_d   = radius_max_q;
    height_min_d   = height_min_q;
    height_max_d   = height_max_q;
    orbit_rate_d   = orbit_rate_q;
    radius_rate_d  = radius_rate_q;
    height_rate_d  = height_rate_q;
    start_angle_d  = start_angle_q;
    orbit_phase_d  = orbit_phase_q;
    radius_phase_d = radius_phase_q;
    height_phase_d = height_phase_q;
    delta_d        = delta_q;
    tgt_x_d        = tgt_x_q;
    tgt_y_d        = tgt_y_q;
    tgt_z_d        = tgt_z_q;
    radius_d       = radius_q;
    height_d       = height_q;
    off_x_d        = off_x_q;
    off_y_d        = off_y_q;
    eye_x_d        = eye_x_q;
    eye_y_d        = eye_y_q;
    eye_z_d        = eye_z_q;
    out_valid_d    = out_valid_q & ~out_ready_i;
    cor_start      = 1'b0;
    cor_phase      = radius_phase_q;
    mul_req.start  = 1'b0;
    mul_req.a      = '0;
    mul_req.b      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          delta_d   = delta_ms_i;
          tgt_x_d   = target_x_i;
          tgt_y_d   = target_y_i;
          tgt_z_d   = target_z_i;
          cor_start = 1'b1;
          cor_phase = radius_phase_q;
          state_d   = S_R_COR;
        end
      end
      S_R_COR: begin
        if (cor_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = r_diff;
          mul_req.b     = t_q30;
          state_d       = S_R_MUL;
        end
      end
      S_R_MUL: begin
        if (mul_rsp.done) begin
          radius_d  = $signed({1'b0, radius_min_q}) + mul_rsp.rnd;
          cor_start = 1'b1;
          cor_phase = height_phase_q;
          state_d   = S_H_COR;
        end
      end
      S_H_COR: begin
        if (cor_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = h_diff;
          mul_req.b     = t_q30;
          state_d       = S_H_MUL;
        end
      end
      S_H_MUL: begin
        if (mul_rsp.done) begin
          height_d  = height_min_q + mul_rsp.rnd;
          cor_start = 1'b1;
          cor_phase = orbit_phase_q;
          state_d   = S_O_COR;
        end
      end
      S_O_COR: begin
        if (cor_done) begin
          mul_req.start = 1'b1;
          mul_req.a     = {radius_q[31], radius_q};
          mul_req.b     = cor_sin;
          state_d       = S_X_MUL;
        end
      end
      S_X_MUL: begin
        // cosine stays in the CORDIC output register until its next start
        if (mul_rsp.done) begin
          off_x_d       = mul_rsp.rnd;
          mul_req.start = 1'b1;
          mul_req.a     = {radius_q[31], radius_q};
          mul_req.b     = cor_cos;
          state_d       = S_Y_MUL;
        end
      end
      S_Y_MUL: begin
        if (mul_rsp.done) begin
          off_y_d = mul_rsp.rnd;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          eye_x_d       = tgt_x_q + off_x_q;
          eye_y_d       = tgt_y_q - off_y_q;
          eye_z_d       = tgt_z_q + height_q;
          out_valid_d   = 1'b1;
          mul_req.start = 1'b1;
          mul_req.a     = $signed({1'b0, orbit_rate_q});
          mul_req.b     = $signed({16'h0000, delta_q});
          state_d       = S_PO_MUL;
        end
      end
      S_PO_MUL: begin
        if (mul_rsp.done) begin
          orbit_phase_d = orbit_phase_q + mul_rsp.prod_lo;
          mul_req.start = 1'b1;
          mul_req.a     = $signed({1'b0, radius_rate_q});
          mul_req.b     = $signed({16'h0000, delta_q});
          state_d       = S_PR_MUL;
        end
      end
      S_PR_MUL: begin
        if (mul_rsp.done) begin
          radius_phase_d = radius_phase_q + mul_rsp.prod_lo;
          mul_req.start  = 1'b1;
          mul_req.a      = $signed({1'b0, height_rate_q});
          mul_req.b      = $signed({16'h0000, delta_q});
          state_d        = S_PH_MUL;
        end
      end
      S_PH_MUL: begin
        if (mul_rsp.done) begin
          height_phase_d = height_phase_q + mul_rsp.prod_lo;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_RADIUS_MIN:  radius_min_d  = cfg_data_i[30:0];
        REG_RADIUS_MAX:  radius_max_d  = cfg_data_i[30:0];
        REG_HEIGHT_MIN:  height_min_d  = $signed(cfg_data_i);
        REG_HEIGHT_MAX:  height_max_d  = $signed(cfg_data_i);
        REG_ORBIT_RATE:  orbit_rate_d  = cfg_data_i;
        REG_RADIUS_RATE: radius_rate_d = cfg_data_i;
        REG_HEIGHT_RATE: height_rate_d = cfg_data_i;
        REG_START_ANGLE: begin
          start_angle_d = cfg_data_i;
          orbit_phase_d = cfg_data_i;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      out_valid_q    <= 1'b0;
      radius_min_q   <= 31'd262144;
      radius_max_q   <= 31'd458752;
      height_min_q   <= 32'sd65536;
      height_max_q   <= 32'sd262144;
      orbit_rate_q   <= 32'd107374;
      radius_rate_q  <= 32'd143166;
      height_rate_q  <= 32'd2386;
      start_angle_q  <= 32'd0;
      orbit_phase_q  <= 32'd0;
      radius_phase_q <= 32'd0;
      height_phase_q <= 32'd0;
    end else begin
      state_q        <= state_d;
      out_valid_q    <= out_valid_d;
      radius_min_q   <= radius_min_d;
      radius_max_q   <= radius_max_d;
      height_min_q   <= height_min_d;
      height_max_q   <= height_max_d;
      orbit_rate_q   <= orbit_rate_d;
      radius_rate_q  <= radius_rate_d;
      height_rate_q  <= height_rate_d;
      start_angle_q  <= start_angle_d;
      orbit_phase_q  <= orbit_phase_d;
      radius_phase_q <= radius_phase_d;
      height_phase_q <= height_phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q  <= delta_d;
    tgt_x_q  <= tgt_x_d;
    tgt_y_q  <= tgt_y_d;
    tgt_z_q  <= tgt_z_d;
    radius_q <= radius_d;
    height_q <= height_d;
    off_x_q  <= off_x_d;
    off_y_q  <= off_y_d;
    eye_x_q  <= eye_x_d;
    eye_y_q  <= eye_y_d;
    eye_z_q  <= eye_z_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign eye_x_o     = eye_x_q;
  assign eye_y_o     = eye_y_q;
  assign eye_z_o     = eye_z_q;

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_R_COR)
    else $error("accepted transaction did not start the radius sweep");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_OUT)
    else $error("result raised outside the output step");

  a_out_blocked_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_OUT && out_valid_o && !out_ready_i |=> state_q == S_OUT)
    else $error("sequencer left the output step while the result was pending");

endmodule

>>> test/orbit_camera_path_generator_tb.sv
// Self-checking testbench for orbit_camera_path_generator: frame transactions
// in, eye points out, predicted by a cycle-free CORDIC model kept in this file.
// Depends on ocpg_pkg for the port widths and register indexes.
`timescale 1ns / 100ps

module orbit_camera_path_generator_tb;
  import ocpg_pkg::*;

  localparam int     SETTLE_CYCLES = 200;   // frame latency plus phase advance, with margin
  localparam int     HOLD_CYCLES   = 400;
  localparam int     TIMEOUT_NS    = 20_000_000;
  localparam int     NUM_REGS      = 8;
  localparam int     MODEL_STEPS   = 16;
  localparam longint Q30           = 64'sd1073741824;
  localparam longint GAIN_ONE      = 64'sh26DD3B6A;
  localparam longint ATAN_TURN [0:15] = '{
    64'sh20000000, 64'sh12E4051E, 64'sh09FB385B, 64'sh051111D4,
    64'sh028B0D43, 64'sh0145D7E1, 64'sh00A2F61E, 64'sh00517C55,
    64'sh0028BE53, 64'sh00145F2F, 64'sh000A2F98, 64'sh000517CC,
    64'sh00028BE6, 64'sh000145F3, 64'sh0000A2FA, 64'sh0000517D
  };
  localparam logic [CFG_IDX_W-1:0] ALL_REGS [0:7] = '{
    REG_RADIUS_MIN, REG_RADIUS_MAX, REG_HEIGHT_MIN, REG_HEIGHT_MAX,
    REG_ORBIT_RATE, REG_RADIUS_RATE, REG_HEIGHT_RATE, REG_START_ANGLE
  };

  typedef struct packed {
    logic [15:0]        dt;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [31:0] tz;
  } frame_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } eye_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [31:0]          cfg_data = '0;
  logic                 frame_valid = 1'b0;
  logic                 frame_ready;
  frame_t               cur_frame = '0;
  logic                 eye_valid;
  logic                 eye_ready = 1'b0;
  logic signed [31:0]   eye_x, eye_y, eye_z;

  logic   in_taken = 1'b0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  int     hold_cmd = 0;
  int     hold_seen = 0;
  int     hold_left = 0;
  int     fail_count = 0;
  frame_t frame_q[$];
  eye_t   eye_due_q[$];

  // predictor copy of the configuration and the phase accumulators
  logic [30:0]        rmin_m = 31'd262144;
  logic [30:0]        rmax_m = 31'd458752;
  logic signed [31:0] hmin_m = 32'sd65536;
  logic signed [31:0] hmax_m = 32'sd262144;
  logic [31:0]        orbit_rate_m = 32'd107374;
  logic [31:0]        radius_rate_m = 32'd143166;
  logic [31:0]        height_rate_m = 32'd2386;
  logic [31:0]        orbit_ph = '0;
  logic [31:0]        radius_ph = '0;
  logic [31:0]        height_ph = '0;

  orbit_camera_path_generator i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (frame_valid),
    .in_ready_o  (frame_ready),
    .delta_ms_i  (cur_frame.dt),
    .target_x_i  (cur_frame.tx),
    .target_y_i  (cur_frame.ty),
    .target_z_i  (cur_frame.tz),
    .out_valid_o (eye_valid),
    .out_ready_i (eye_ready),
    .eye_x_o     (eye_x),
    .eye_y_o     (eye_y),
    .eye_z_o     (eye_z)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void cordic_sincos(input logic [31:0] phase,
                                        output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = GAIN_ONE;
    y = 0;
    z = longint'({34'd0, phase[29:0]});
    for (int i = 0; i < MODEL_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_TURN[i];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_TURN[i];
      end
    end
    // fold the first-quadrant result onto the full circle
    case (phase[31:30])
      2'd0:    begin c = x;  s = y;  end
      2'd1:    begin c = -y; s = x;  end
      2'd2:    begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
  endfunction

  function automatic longint sweep_between(input longint lo, input longint hi,
                                           input logic [31:0] phase);
    longint s, c, t;
    cordic_sincos(phase, s, c);
    t = (s + Q30) >>> 1;
    if (t < 0) t = 0;
    if (t > Q30) t = Q30;
    return lo + (((hi - lo) * t + (Q30 >>> 1)) >>> 30);
  endfunction

  task automatic predict_eye(input frame_t f);
    longint r, h, s, c, ox, oy;
    eye_t   e;
    r = sweep_between(longint'(rmin_m), longint'(rmax_m), radius_ph);
    h = sweep_between(longint'(hmin_m), longint'(hmax_m), height_ph);
    cordic_sincos(orbit_ph, s, c);
    ox = (r * s + (Q30 >>> 1)) >>> 30;
    oy = -((r * c + (Q30 >>> 1)) >>> 30);
    e.x = 32'(longint'(f.tx) + ox);
    e.y = 32'(longint'(f.ty) + oy);
    e.z = 32'(longint'(f.tz) + h);
    eye_due_q.push_back(e);
    // advance after the eye point, modulo 2^32
    orbit_ph  = orbit_ph + orbit_rate_m * f.dt;
    radius_ph = radius_ph + radius_rate_m * f.dt;
    height_ph = height_ph + height_rate_m * f.dt;
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
    end
  endfunction

  // sender: hold the payload until the transaction is taken
  always @(negedge clk) begin
    if (!frame_valid || in_taken) begin
      if (frame_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        cur_frame   <= frame_q.pop_front();
        frame_valid <= 1'b1;
      end else begin
        frame_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_cmd != hold_seen) begin
      hold_seen <= hold_cmd;
      hold_left <= HOLD_CYCLES;
      eye_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      eye_ready <= 1'b0;
    end else begin
      eye_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    eye_t want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= frame_valid && frame_ready;
      if (frame_valid && frame_ready) predict_eye(cur_frame);
      if (eye_valid && eye_ready) begin
        if (eye_due_q.size() == 0) begin
          fail_count++;
          $display("%0t unexpected eye point: expected none actual %h %h %h",
                   $time, eye_x, eye_y, eye_z);
        end else begin
          want = eye_due_q.pop_front();
          check_field("eye_x", want.x, eye_x);
          check_field("eye_y", want.y, eye_y);
          check_field("eye_z", want.z, eye_z);
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] v);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = v;
    case (idx)
      REG_RADIUS_MIN:  rmin_m = v[30:0];
      REG_RADIUS_MAX:  rmax_m = v[30:0];
      REG_HEIGHT_MIN:  hmin_m = v;
      REG_HEIGHT_MAX:  hmax_m = v;
      REG_ORBIT_RATE:  orbit_rate_m = v;
      REG_RADIUS_RATE: radius_rate_m = v;
      REG_HEIGHT_RATE: height_rate_m = v;
      REG_START_ANGLE: orbit_ph = v;
      default: ;  // unmapped index, drop
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic push_frame(input logic [15:0] dt, input logic [31:0] x,
                            input logic [31:0] y, input logic [31:0] z);
    frame_q.push_back('{dt, x, y, z});
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (frame_q.size() != 0 || frame_valid || eye_due_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1:       begin send_idle_pct = 55; recv_stall_pct = 0;  end
      2:       begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default: begin send_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  function automatic logic [31:0] rand_reg_value();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4, 5:    return $urandom_range(32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom_range(32'h0020_0000) - 32'h0010_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic frame_t rand_frame();
    frame_t f;
    case ($urandom_range(9))
      0:       f.dt = 16'($urandom);
      1, 2:    f.dt = 16'($urandom_range(1000));
      default: f.dt = 16'($urandom_range(40));
    endcase
    f.tx = rand_coord();
    f.ty = rand_coord();
    f.tz = rand_coord();
    return f;
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset configuration; zero delta keeps the phases still
    push_frame(16'd0, 32'h0, 32'h0, 32'h0);
    push_frame(16'd0, 32'h0, 32'h0, 32'h0);
    push_frame(16'd1000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_frame(16'hFFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_frame(16'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();

    // widest sweeps, quarter-turn steps walk through every quadrant
    write_reg(REG_RADIUS_MIN, 32'h0);
    write_reg(REG_RADIUS_MAX, 32'h7FFF_FFFF);
    write_reg(REG_HEIGHT_MIN, 32'h8000_0000);
    write_reg(REG_HEIGHT_MAX, 32'h7FFF_FFFF);
    write_reg(REG_ORBIT_RATE, 32'h4000_0000);
    write_reg(REG_RADIUS_RATE, 32'h4000_0000);
    write_reg(REG_HEIGHT_RATE, 32'h4000_0000);
    write_reg(REG_START_ANGLE, 32'hC000_0000);
    for (int k = 0; k < 5; k++)
      push_frame(16'd1, rand_coord(), rand_coord(), rand_coord());
    wait_idle();

    // minimum above maximum, largest rates, unmapped indexes ignored
    write_reg(REG_RADIUS_MIN, 32'hFFFF_FFFF);
    write_reg(REG_RADIUS_MAX, 32'h8000_0000);
    write_reg(REG_HEIGHT_MIN, 32'h7FFF_FFFF);
    write_reg(REG_HEIGHT_MAX, 32'h8000_0000);
    write_reg(REG_ORBIT_RATE, 32'hFFFF_FFFF);
    write_reg(REG_RADIUS_RATE, 32'hFFFF_FFFF);
    write_reg(REG_HEIGHT_RATE, 32'hFFFF_FFFF);
    write_reg(REG_START_ANGLE, 32'h3FFF_FFFF);
    write_reg(4'(NUM_REGS), 32'h1234_5678);
    write_reg(4'((1 << CFG_IDX_W) - 1), 32'hFFFF_FFFF);
    push_frame(16'hFFFF, 32'h0, 32'h0, 32'h0);
    push_frame(16'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    push_frame(16'h8000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_frame(16'd1, 32'h0, 32'h0, 32'h0);
    wait_idle();

    // reload the orbit phase mid-run, all rates stopped
    write_reg(REG_ORBIT_RATE, 32'h0);
    write_reg(REG_RADIUS_RATE, 32'h0);
    write_reg(REG_HEIGHT_RATE, 32'h0);
    write_reg(REG_START_ANGLE, 32'h8000_0000);
    push_frame(16'd500, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
    push_frame(16'hFFFF, 32'h0001_0000, 32'hFFFF_0000, 32'h0);
    wait_idle();

    for (int ph = 0; ph < 14; ph++) begin
      set_idling(ph % 4);
      foreach (ALL_REGS[k]) write_reg(ALL_REGS[k], rand_reg_value());
      if ($urandom_range(1))
        write_reg(4'($urandom_range(NUM_REGS, (1 << CFG_IDX_W) - 1)), $urandom);
      for (int k = 0; k < 100; k++) frame_q.push_back(rand_frame());
      // stall the output while frames keep arriving
      if (ph == 5 || ph == 11) hold_cmd++;
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("[orbit_camera_path_generator] OK");
    end else begin
      $display("[orbit_camera_path_generator] ERROR");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("[orbit_camera_path_generator] ERROR");
    $finish;
  end

endmodule
